[rtl/core/assert_macros.svh]
// Assertion macros shared by the guard core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/tdog_pkg.sv]
// Types and constants of the track driver overcurrent guard.
package tdog_pkg;

  // Item kinds carried on in_tuser.
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_SIGNAL = 3'd1;
  localparam logic [2:0] FUNC_BRAKE  = 3'd2;
  localparam logic [2:0] FUNC_POWER  = 3'd3;
  localparam logic [2:0] FUNC_INIT   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_SCHEME   = 3'd0;
  localparam logic [2:0] REG_B_IDLE   = 3'd1;
  localparam logic [2:0] REG_EN_MODE  = 3'd2;
  localparam logic [2:0] REG_SL_MODE  = 3'd3;
  localparam logic [2:0] REG_TRIP_MA  = 3'd4;
  localparam logic [2:0] REG_MA_PER   = 3'd5;
  localparam logic [2:0] REG_SMOOTH   = 3'd6;
  localparam logic [2:0] REG_RETRY    = 3'd7;

  // Control schemes.
  localparam logic [1:0] CS_SINGLE = 2'd0;
  localparam logic [1:0] CS_DUAL   = 2'd1;
  localparam logic [1:0] CS_DBE    = 2'd2;

  // Enable / sleep pin modes: idle low, idle high; anything else is unused.
  localparam logic [1:0] PM_IDLE_LOW  = 2'd0;
  localparam logic [1:0] PM_IDLE_HIGH = 2'd1;
  localparam logic [1:0] PM_UNUSED    = 2'd2;

  // Field widths.
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned ADC_W    = 10;
  localparam int unsigned CUR_W    = 18;
  localparam int unsigned AVG_W    = 18;
  localparam int unsigned MPC_W    = 16;
  localparam int unsigned SMOOTH_W = 9;
  localparam int unsigned RETRY_W  = 16;
  localparam int unsigned CFG_W    = 18;
  localparam int unsigned IN_W     = 16;
  localparam int unsigned OUT_W    = 24;

  // Serial multiply-accumulate widths.
  localparam int unsigned MAC_W = 34;
  localparam int unsigned MPL_W = 16;

  // Q-format positions and rounding constants.
  localparam int unsigned AVG_FRAC = 8;
  localparam int unsigned CUR_FRAC = 16;
  localparam logic [MAC_W-1:0] AVG_ROUND = MAC_W'(128);
  localparam logic [MAC_W-1:0] CUR_ROUND = MAC_W'(32768);
  localparam logic [SMOOTH_W-1:0] SMOOTH_ONE = SMOOTH_W'(256);

  // Control to the serial multiply-accumulate unit.
  typedef struct packed {
    logic start;     // load operands, begin shifting
    logic keep_acc;  // add onto the present sum instead of the init value
  } mac_cmd_t;

endpackage

[rtl/core/tdog_mac.sv]
// Bit-serial multiply-accumulate unit: one multiplier bit per cycle.
`include "assert_macros.svh"

module tdog_mac (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tdog_pkg::mac_cmd_t         cmd_i,
  input  logic [tdog_pkg::MAC_W-1:0] mcand_i,
  input  logic [tdog_pkg::MPL_W-1:0] mplier_i,
  input  logic [tdog_pkg::MAC_W-1:0] acc_init_i,
  output logic [tdog_pkg::MAC_W-1:0] acc_o,
  output logic                       busy_o
);
  import tdog_pkg::*;

  logic [MAC_W-1:0] mcand_r, mcand_nxt;
  logic [MPL_W-1:0] mplier_r, mplier_nxt;
  logic [MAC_W-1:0] acc_r, acc_nxt;

  assign busy_o = (mplier_r != '0);
  assign acc_o  = acc_r;

  always_comb begin
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    if (cmd_i.start) begin
      mcand_nxt  = mcand_i;
      mplier_nxt = mplier_i;
      acc_nxt    = cmd_i.keep_acc ? acc_r : acc_init_i;
    end else if (busy_o) begin
      // add the shifted multiplicand for a set bit, then step one bit
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mplier_r <= '0;
      mcand_r  <= '0;
      acc_r    <= '0;
    end else begin
      mplier_r <= mplier_nxt;
      mcand_r  <= mcand_nxt;
      acc_r    <= acc_nxt;
    end
  end

  `ASSERT_NEXT(mac_step_shift, busy_o && !cmd_i.start, mplier_r == ($past(mplier_r) >> 1))
  `ASSERT_NEXT(mac_idle_holds, !busy_o && !cmd_i.start, $stable(acc_r))
  `ASSERT_NEXT(mac_start_loads, cmd_i.start, mplier_r == $past(mplier_i))

endmodule

[rtl/core/track_driver_overcurrent_guard_core.sv]
// Track driver overcurrent guard: pin control and overcurrent trip/retry.
// Each input item is a millisecond tick with a current-sense sample or a
// pin command (signal, brake, power, initialise), selected by in_tuser; each
// yields exactly one result item with the four pin levels, the tripped flag
// and the latest smoothed current in mA. A command goes from ST_IDLE straight
// to ST_PUT, which loads the output register; so does a tick, except every
// SAMPLE_TICKS-th tick, which runs a check: the moving average and the mA
// scaling go through one shared bit-serial multiply-accumulate unit, one
// multiplier bit per cycle, in three passes (new-sample weight, old-average
// weight, mA per count) in ST_MUL_A, ST_MUL_B and ST_MUL_C; each pass ends
// once its multiplier has no set bit left. The block takes one item at a
// time; the result sits in an output register, so a stalled result channel
// does not hold back the next item until its own result is ready.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while the block is idle; they never re-drive a pin.
`include "assert_macros.svh"

module track_driver_overcurrent_guard_core #(
  parameter int SAMPLE_TICKS = 1  // ticks between checks, 0 acts as 1, up to 1000
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: [0] level, [10:1] adc_sample, [15:11] zero
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tdog_pkg::IN_W-1:0]   in_tdata,
  // in_tuser: [2:0] func
  input  logic [tdog_pkg::FUNC_W-1:0] in_tuser,
  // out_tdata: [0] pin_signal_a, [1] pin_signal_b, [2] pin_enable,
  //            [3] pin_sleep, [4] is_tripped, [22:5] current_ma, [23] zero
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tdog_pkg::OUT_W-1:0]  out_tdata,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [tdog_pkg::CFG_W-1:0]  cfg_data
);
  import tdog_pkg::*;

  localparam int PERIOD = (SAMPLE_TICKS < 1) ? 1 : SAMPLE_TICKS;
  localparam int TSC_W  = $clog2(PERIOD + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_A = 3'd1;  // sample * weight
  localparam logic [2:0] ST_MUL_B = 3'd2;  // old average * (1 - weight)
  localparam logic [2:0] ST_MUL_C = 3'd3;  // average * mA per count
  localparam logic [2:0] ST_PUT   = 3'd4;  // hand the result to the output register

  // Enable/sleep pin level for a power change; an unused pin holds its level.
  function automatic logic power_pin(input logic on, input logic [1:0] mode,
                                     input logic cur);
    logic res;
    res = cur;
    if (mode inside {PM_IDLE_LOW, PM_IDLE_HIGH}) begin
      res = mode[0] ^ on;
    end
    return res;
  endfunction

  // Configuration registers.
  logic [1:0]          scheme_r;
  logic                b_idle_r;
  logic [1:0]          en_mode_r;
  logic [1:0]          sl_mode_r;
  logic [CUR_W-1:0]    trip_ma_r;
  logic [MPC_W-1:0]    ma_per_r;
  logic [SMOOTH_W-1:0] smooth_r;
  logic [RETRY_W-1:0]  retry_r;

  // Guard state.
  logic [2:0]         state_r, state_nxt;
  logic [AVG_W-1:0]   avg_r, avg_nxt;
  logic [TSC_W-1:0]   tsc_r, tsc_nxt;
  logic [RETRY_W-1:0] tst_r, tst_nxt;
  logic               tripped_r, tripped_nxt;
  logic               power_r, power_nxt;
  logic               pin_a_r, pin_a_nxt;
  logic               pin_b_r, pin_b_nxt;
  logic               pin_en_r, pin_en_nxt;
  logic               pin_sl_r, pin_sl_nxt;
  logic [CUR_W-1:0]   cur_r, cur_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;

  // Item decode.
  logic                in_fire;
  logic [FUNC_W-1:0]   func;
  logic                level;
  logic [ADC_W-1:0]    sample;
  logic [1:0]          scheme;
  logic [SMOOTH_W-1:0] s_sat;
  logic [SMOOTH_W-1:0] s_rest;
  logic [TSC_W-1:0]    tsc_inc;
  logic [AVG_W-1:0]    avg_new;
  logic [CUR_W-1:0]    cur_new;

  // Serial unit hookup.
  mac_cmd_t         mac_cmd;
  logic [MAC_W-1:0] mac_mcand;
  logic [MPL_W-1:0] mac_mplier;
  logic [MAC_W-1:0] mac_init;
  logic [MAC_W-1:0] mac_acc;
  logic             mac_busy;

  tdog_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (mac_cmd),
    .mcand_i    (mac_mcand),
    .mplier_i   (mac_mplier),
    .acc_init_i (mac_init),
    .acc_o      (mac_acc),
    .busy_o     (mac_busy)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign func       = in_tuser;
  assign level      = in_tdata[0];
  assign sample     = in_tdata[ADC_W:1];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  // Scheme three acts as single direction; weight saturates at one.
  assign scheme  = (scheme_r inside {CS_DUAL, CS_DBE}) ? scheme_r : CS_SINGLE;
  assign s_sat   = (smooth_r > SMOOTH_ONE) ? SMOOTH_ONE : smooth_r;
  assign s_rest  = SMOOTH_ONE - s_sat;
  assign tsc_inc = tsc_r + TSC_W'(1);
  // Average is Q10.8 after dropping 8 fraction bits of the weighted sum;
  // current drops the 16 fraction bits of the Q10.8 x Q8.8 product.
  assign avg_new = mac_acc[AVG_FRAC +: AVG_W];
  assign cur_new = mac_acc[CUR_FRAC +: CUR_W];

  always_comb begin
    state_nxt     = state_r;
    avg_nxt       = avg_r;
    tsc_nxt       = tsc_r;
    tst_nxt       = tst_r;
    tripped_nxt   = tripped_r;
    power_nxt     = power_r;
    pin_a_nxt     = pin_a_r;
    pin_b_nxt     = pin_b_r;
    pin_en_nxt    = pin_en_r;
    pin_sl_nxt    = pin_sl_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    mac_cmd       = '0;
    mac_mcand     = '0;
    mac_mplier    = '0;
    mac_init      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_PUT;
          case (func)
            FUNC_TICK: begin
              if (tst_r != '1) begin
                tst_nxt = tst_r + RETRY_W'(1);
              end
              if (tsc_inc >= TSC_W'(PERIOD)) begin
                // run a check: start with sample * weight, Q10.8 scaled
                tsc_nxt          = '0;
                mac_cmd.start    = 1'b1;
                mac_cmd.keep_acc = 1'b0;
                mac_mcand        = MAC_W'({sample, {AVG_FRAC{1'b0}}});
                mac_mplier       = MPL_W'(s_sat);
                mac_init         = AVG_ROUND;
                state_nxt        = ST_MUL_A;
              end else begin
                tsc_nxt = tsc_inc;
              end
            end
            FUNC_SIGNAL: begin
              pin_a_nxt = level;
              if (scheme == CS_DUAL) begin
                pin_b_nxt = ~level;
              end
            end
            FUNC_BRAKE: begin
              if (scheme == CS_DUAL) begin
                pin_a_nxt = ~level;
                pin_b_nxt = ~level;
              end else if (scheme == CS_DBE) begin
                pin_b_nxt = level ^ b_idle_r;
              end
            end
            FUNC_POWER: begin
              power_nxt  = level;
              pin_en_nxt = power_pin(level, en_mode_r, pin_en_r);
              pin_sl_nxt = power_pin(level, sl_mode_r, pin_sl_r);
            end
            FUNC_INIT: begin
              pin_a_nxt   = 1'b0;
              pin_b_nxt   = (scheme != CS_SINGLE) ? b_idle_r : 1'b0;
              pin_en_nxt  = power_pin(1'b0, en_mode_r, 1'b0);
              pin_sl_nxt  = power_pin(1'b0, sl_mode_r, 1'b0);
              power_nxt   = 1'b0;
              tripped_nxt = 1'b0;
            end
            default: begin
              // unknown kinds change nothing and report the present outputs
            end
          endcase
        end
      end

      ST_MUL_A: begin
        if (!mac_busy) begin
          // add old average * (1 - weight) onto the sum
          mac_cmd.start    = 1'b1;
          mac_cmd.keep_acc = 1'b1;
          mac_mcand        = MAC_W'(avg_r);
          mac_mplier       = MPL_W'(s_rest);
          state_nxt        = ST_MUL_B;
        end
      end

      ST_MUL_B: begin
        if (!mac_busy) begin
          // latch the new average, then scale it to mA
          avg_nxt          = avg_new;
          mac_cmd.start    = 1'b1;
          mac_cmd.keep_acc = 1'b0;
          mac_mcand        = MAC_W'(avg_new);
          mac_mplier       = ma_per_r;
          mac_init         = CUR_ROUND;
          state_nxt        = ST_MUL_C;
        end
      end

      ST_MUL_C: begin
        if (!mac_busy) begin
          cur_nxt   = cur_new;
          state_nxt = ST_PUT;
          if ((cur_new > trip_ma_r) && power_r) begin
            // overcurrent: cut power and restart the retry count
            power_nxt   = 1'b0;
            pin_en_nxt  = power_pin(1'b0, en_mode_r, pin_en_r);
            pin_sl_nxt  = power_pin(1'b0, sl_mode_r, pin_sl_r);
            tripped_nxt = 1'b1;
            tst_nxt     = '0;
          end else if ((cur_new < trip_ma_r) && tripped_r && (tst_r > retry_r)) begin
            // current back below the trigger and the retry time is over
            power_nxt   = 1'b1;
            pin_en_nxt  = power_pin(1'b1, en_mode_r, pin_en_r);
            pin_sl_nxt  = power_pin(1'b1, sl_mode_r, pin_sl_r);
            tripped_nxt = 1'b0;
          end
        end
      end

      ST_PUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, cur_r, tripped_r, pin_sl_r, pin_en_r, pin_b_r, pin_a_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      avg_r       <= '0;
      tsc_r       <= '0;
      tst_r       <= '0;
      tripped_r   <= 1'b0;
      power_r     <= 1'b0;
      pin_a_r     <= 1'b0;
      pin_b_r     <= 1'b0;
      pin_en_r    <= 1'b0;
      pin_sl_r    <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      avg_r       <= avg_nxt;
      tsc_r       <= tsc_nxt;
      tst_r       <= tst_nxt;
      tripped_r   <= tripped_nxt;
      power_r     <= power_nxt;
      pin_a_r     <= pin_a_nxt;
      pin_b_r     <= pin_b_nxt;
      pin_en_r    <= pin_en_nxt;
      pin_sl_r    <= pin_sl_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scheme_r  <= CS_SINGLE;
      b_idle_r  <= 1'b0;
      en_mode_r <= PM_UNUSED;
      sl_mode_r <= PM_UNUSED;
      trip_ma_r <= CUR_W'(2000);
      ma_per_r  <= MPC_W'(2500);
      smooth_r  <= SMOOTH_W'(64);
      retry_r   <= RETRY_W'(10000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCHEME:  scheme_r  <= cfg_data[1:0];
        REG_B_IDLE:  b_idle_r  <= cfg_data[0];
        REG_EN_MODE: en_mode_r <= cfg_data[1:0];
        REG_SL_MODE: sl_mode_r <= cfg_data[1:0];
        REG_TRIP_MA: trip_ma_r <= cfg_data[CUR_W-1:0];
        REG_MA_PER:  ma_per_r  <= cfg_data[MPC_W-1:0];
        REG_SMOOTH:  smooth_r  <= cfg_data[SMOOTH_W-1:0];
        REG_RETRY:   retry_r   <= cfg_data[RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  `ASSERT_NEXT(cmd_to_put, in_fire && (func != FUNC_TICK), state_r == ST_PUT)
  `ASSERT_IMPL(mac_quiet_in_idle, state_r == ST_IDLE, !mac_busy)
  `ASSERT_NEXT(check_done_to_put, (state_r == ST_MUL_C) && !mac_busy, state_r == ST_PUT)

endmodule

[tb/tb_track_driver_overcurrent_guard_core.sv]
// Self-checking testbench for the track driver overcurrent guard core.
module tb_track_driver_overcurrent_guard_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tdog_pkg::*;

  // Ticks between current checks; the core treats 0 as 1.
  localparam int CHECK_PERIOD = 1;
  localparam int CHECK_EVERY  = (CHECK_PERIOD < 1) ? 1 : CHECK_PERIOD;

  // Item kinds that the core leaves without effect.
  localparam logic [2:0] FUNC_RSVD5 = 3'd5;
  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 60;
  localparam int REPORT_MAX      = 10;

  // One command or tick as it travels on the input channel.
  typedef struct {
    logic [2:0] func;
    logic       level;
    logic [9:0] sample;
  } guard_cmd_t;

  // Result layout, same bit order as out_tdata[22:0].
  typedef struct packed {
    logic [CUR_W-1:0] current_ma;
    logic             tripped;
    logic             pin_sl;
    logic             pin_en;
    logic             pin_b;
    logic             pin_a;
  } pin_report_t;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata  = '0;
  logic [FUNC_W-1:0] in_tuser  = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;

  track_driver_overcurrent_guard_core #(
    .SAMPLE_TICKS(CHECK_PERIOD)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the registers, starting at their reset values.
  logic [1:0]         scheme_r       = CS_SINGLE;
  logic               b_idle_r       = 1'b0;
  logic [1:0]         en_mode_r      = PM_UNUSED;
  logic [1:0]         sl_mode_r      = PM_UNUSED;
  logic [CUR_W-1:0]   trip_ma_r      = 18'd2000;
  logic [MPC_W-1:0]   ma_per_count_r = 16'd2500;
  logic [SMOOTH_W-1:0] smooth_r      = 9'd64;
  logic [RETRY_W-1:0] retry_r        = 16'd10000;

  // Shadow copy of the guard state, all clear after reset.
  logic [AVG_W-1:0] avg_q8           = '0;
  logic [15:0]      ticks_to_check   = '0;
  logic [15:0]      ticks_after_trip = '0;
  logic             trip_flag        = 1'b0;
  logic             power_is_on      = 1'b0;
  logic             pin_a = 1'b0, pin_b = 1'b0, pin_en = 1'b0, pin_sl = 1'b0;
  logic [CUR_W-1:0] cur_ma           = '0;

  guard_cmd_t  pending_items[$];
  pin_report_t expected_reports[$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          in_fire     = 1'b0;
  bit          in_gaps_on  = 1'b1;
  bit          out_gaps_on = 1'b1;
  int unsigned in_gap      = 0;
  int unsigned out_hold    = 0;
  pin_report_t got_report;
  pin_report_t want_report;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap length: mostly none, often a few cycles, now and then a long one.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive the enable and sleep pins for a power change; unused pins keep their level.
  function automatic void set_power(logic on);
    power_is_on = on;
    if (en_mode_r == PM_IDLE_LOW || en_mode_r == PM_IDLE_HIGH) pin_en = on ^ en_mode_r[0];
    if (sl_mode_r == PM_IDLE_LOW || sl_mode_r == PM_IDLE_HIGH) pin_sl = on ^ sl_mode_r[0];
  endfunction

  // Advance the shadow guard by one item and return the report it produces.
  function automatic pin_report_t advance_guard(logic [2:0] func, logic level,
                                                logic [9:0] sample);
    longint unsigned wt;
    longint unsigned acc;
    longint unsigned prod;
    pin_report_t     rep;
    case (func)
      FUNC_TICK: begin
        if (ticks_after_trip != 16'hFFFF) ticks_after_trip++;
        if (ticks_to_check != 16'hFFFF) ticks_to_check++;
        if (ticks_to_check >= 16'(CHECK_EVERY)) begin
          ticks_to_check = '0;
          // New sample weight saturates at one; both roundings go half up.
          wt = (smooth_r > SMOOTH_ONE) ? 64'(SMOOTH_ONE) : 64'(smooth_r);
          acc = ((64'(sample) << 8) * wt) + (64'(avg_q8) * (64'd256 - wt)) + 64'd128;
          avg_q8 = AVG_W'(acc >> 8);
          prod = (64'(avg_q8) * 64'(ma_per_count_r) + 64'd32768) >> 16;
          cur_ma = (prod > 64'h3FFFF) ? 18'h3FFFF : CUR_W'(prod);
          if (cur_ma > trip_ma_r && power_is_on) begin
            set_power(1'b0);
            trip_flag = 1'b1;
            ticks_after_trip = '0;
          end else if (cur_ma < trip_ma_r && trip_flag && ticks_after_trip > retry_r) begin
            set_power(1'b1);
            trip_flag = 1'b0;
          end
        end
      end
      FUNC_SIGNAL: begin
        pin_a = level;
        if (scheme_r == CS_DUAL) pin_b = ~level;
      end
      FUNC_BRAKE: begin
        if (scheme_r == CS_DUAL) begin
          pin_a = ~level;
          pin_b = ~level;
        end else if (scheme_r == CS_DBE) begin
          pin_b = level ^ b_idle_r;
        end
      end
      FUNC_POWER: set_power(level);
      FUNC_INIT: begin
        pin_a = 1'b0;
        pin_b = (scheme_r == CS_DUAL || scheme_r == CS_DBE) ? b_idle_r : 1'b0;
        pin_en = (en_mode_r == PM_IDLE_LOW || en_mode_r == PM_IDLE_HIGH) ? en_mode_r[0] : 1'b0;
        pin_sl = (sl_mode_r == PM_IDLE_LOW || sl_mode_r == PM_IDLE_HIGH) ? sl_mode_r[0] : 1'b0;
        power_is_on = 1'b0;
        trip_flag = 1'b0;
      end
      default: ;
    endcase
    rep.pin_a      = pin_a;
    rep.pin_b      = pin_b;
    rep.pin_en     = pin_en;
    rep.pin_sl     = pin_sl;
    rep.tripped    = trip_flag;
    rep.current_ma = cur_ma;
    return rep;
  endfunction

  // Input driver: present the next pending item at the falling edge, with random gaps.
  always @(negedge clk) begin
    if (!in_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (pending_items.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_items[0].func;
        in_tdata  <= {5'd0, pending_items[0].sample, pending_items[0].level};
        void'(pending_items.pop_front());
        in_gap = in_gaps_on ? draw_gap() : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result backpressure: hold ready low for random stretches.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_tready <= 1'b0;
      out_hold--;
    end else begin
      out_tready <= 1'b1;
      out_hold = out_gaps_on ? draw_gap() : 0;
    end
  end

  // Monitor: check results, predict accepted items, mirror register writes.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
    in_fire = rst_n && in_tvalid && in_tready;

    // Compare the result first: it can never belong to an item taken at this edge.
    if (rst_n && out_tvalid && out_tready) begin
      got_report = out_tdata[22:0];
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result item %h at cycle %0d", out_tdata, cycle_count);
      end else begin
        want_report = expected_reports.pop_front();
        if (got_report.pin_a      !== want_report.pin_a   ||
            got_report.pin_b      !== want_report.pin_b   ||
            got_report.pin_en     !== want_report.pin_en  ||
            got_report.pin_sl     !== want_report.pin_sl  ||
            got_report.tripped    !== want_report.tripped ||
            got_report.current_ma !== want_report.current_ma) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $write("mismatch at cycle %0d: want a=%0d b=%0d en=%0d sl=%0d trip=%0d mA=%0d, ",
                   cycle_count, want_report.pin_a, want_report.pin_b, want_report.pin_en,
                   want_report.pin_sl, want_report.tripped, want_report.current_ma);
            $display("got a=%0d b=%0d en=%0d sl=%0d trip=%0d mA=%0d",
                     got_report.pin_a, got_report.pin_b, got_report.pin_en,
                     got_report.pin_sl, got_report.tripped, got_report.current_ma);
          end
        end
      end
    end

    if (in_fire)
      expected_reports.push_back(advance_guard(in_tuser, in_tdata[0], in_tdata[10:1]));

    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCHEME:  scheme_r       = cfg_data[1:0];
        REG_B_IDLE:  b_idle_r       = cfg_data[0];
        REG_EN_MODE: en_mode_r      = cfg_data[1:0];
        REG_SL_MODE: sl_mode_r      = cfg_data[1:0];
        REG_TRIP_MA: trip_ma_r      = cfg_data[CUR_W-1:0];
        REG_MA_PER:  ma_per_count_r = cfg_data[MPC_W-1:0];
        REG_SMOOTH:  smooth_r       = cfg_data[SMOOTH_W-1:0];
        REG_RETRY:   retry_r        = cfg_data[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  task automatic queue_item(input logic [2:0] func, input logic level,
                            input logic [9:0] sample);
    guard_cmd_t c;
    c.func = func;
    c.level = level;
    c.sample = sample;
    pending_items.push_back(c);
  endtask

  // Write one register; ready is sampled at the rising edge.
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Block until every queued item went in and every result came back.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_reports.size() != 0);
  endtask

  // Stimulus: reset defaults, a directed walk through trip and retry, then random phases.
  initial begin
    logic [CFG_W-1:0] reg_val[8];
    int unsigned mpc, trip, th, max_cur, r;
    logic [9:0]  smp;
    bit          hi;

    hi = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Reset configuration: pins unused, default threshold and scaling.
    queue_item(FUNC_TICK, 1'b0, 10'd1023);   // above trip but power off: no trip
    queue_item(FUNC_POWER, 1'b1, 10'd0);     // enable and sleep unused: pins stay low
    queue_item(FUNC_TICK, 1'b1, 10'd1023);   // overcurrent with power on: trip
    queue_item(FUNC_SIGNAL, 1'b1, 10'd0);
    queue_item(FUNC_INIT, 1'b0, 10'd0);
    wait_drained();

    // One mA per count and full weight, so the current equals the sample.
    reg_val[REG_SCHEME]  = CFG_W'(CS_DBE);
    reg_val[REG_B_IDLE]  = CFG_W'(1);
    reg_val[REG_EN_MODE] = CFG_W'(PM_IDLE_LOW);
    reg_val[REG_SL_MODE] = CFG_W'(PM_IDLE_HIGH);
    reg_val[REG_TRIP_MA] = CFG_W'(500);
    reg_val[REG_MA_PER]  = CFG_W'(256);
    reg_val[REG_SMOOTH]  = CFG_W'(SMOOTH_ONE);
    reg_val[REG_RETRY]   = CFG_W'(2);
    for (int i = 0; i < 8; i++) write_reg(3'(i), reg_val[i]);
    @(negedge clk) cfg_valid <= 1'b0;

    queue_item(FUNC_INIT, 1'b0, 10'd0);
    queue_item(FUNC_SIGNAL, 1'b1, 10'd0);
    queue_item(FUNC_BRAKE, 1'b1, 10'd0);
    queue_item(FUNC_BRAKE, 1'b0, 10'd0);
    queue_item(FUNC_SIGNAL, 1'b0, 10'd0);
    queue_item(FUNC_POWER, 1'b1, 10'd0);
    queue_item(FUNC_TICK, 1'b0, 10'd501);    // just over the threshold: trip
    queue_item(FUNC_POWER, 1'b1, 10'd0);     // power back on, tripped flag kept
    queue_item(FUNC_TICK, 1'b0, 10'd500);    // exactly at the threshold: no change
    queue_item(FUNC_TICK, 1'b0, 10'd0);      // low, retry time not yet passed
    queue_item(FUNC_TICK, 1'b0, 10'd0);      // retry time passed: restore
    queue_item(FUNC_TICK, 1'b1, 10'd1023);
    queue_item(FUNC_POWER, 1'b0, 10'd0);
    queue_item(FUNC_TICK, 1'b0, 10'd0);
    queue_item(FUNC_TICK, 1'b0, 10'd0);
    queue_item(FUNC_TICK, 1'b0, 10'd0);      // restore even though power was commanded off
    queue_item(FUNC_RSVD5, 1'b1, 10'd1023);
    queue_item(FUNC_RSVD6, 1'b0, 10'd0);
    queue_item(FUNC_RSVD7, 1'b1, 10'h155);
    queue_item(FUNC_INIT, 1'b1, 10'h2AA);
    queue_item(FUNC_BRAKE, 1'b1, 10'd0);
    queue_item(FUNC_TICK, 1'b0, 10'd1023);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      reg_val[REG_SCHEME]  = CFG_W'($urandom_range(0, 3));
      reg_val[REG_B_IDLE]  = CFG_W'($urandom_range(0, 1));
      reg_val[REG_EN_MODE] = CFG_W'($urandom_range(0, 3));
      reg_val[REG_SL_MODE] = CFG_W'($urandom_range(0, 3));
      reg_val[REG_SMOOTH]  = ($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(0, 511))
                                                         : CFG_W'($urandom_range(24, 256));
      reg_val[REG_RETRY]   = ($urandom_range(0, 5) == 0) ? CFG_W'($urandom_range(0, 65535))
                                                         : CFG_W'($urandom_range(0, 40));
      mpc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(64, 4096);
      // Force the register extremes in the first phases.
      case (p)
        0: reg_val[REG_SMOOTH] = '0;
        1: begin
          reg_val[REG_SMOOTH] = CFG_W'(511);
          mpc = 65535;
        end
        2: reg_val[REG_RETRY] = CFG_W'(65535);
        3: begin
          reg_val[REG_RETRY]  = '0;
          reg_val[REG_SMOOTH] = CFG_W'(SMOOTH_ONE);
        end
        4: mpc = 0;
        5: begin
          reg_val[REG_SCHEME]  = CFG_W'(3);
          reg_val[REG_EN_MODE] = CFG_W'(3);
          reg_val[REG_SL_MODE] = CFG_W'(3);
        end
        default: ;
      endcase
      max_cur = (1023 * mpc) >> 8;
      trip = $urandom_range(0, max_cur);
      if (p == 1) trip = 262143;
      if (p == 3) trip = 0;
      reg_val[REG_MA_PER]  = CFG_W'(mpc);
      reg_val[REG_TRIP_MA] = CFG_W'(trip);
      // Sample level that roughly maps onto the threshold.
      th = (mpc == 0) ? 1023 : (trip * 256) / mpc;
      if (th > 1023) th = 1023;

      for (int i = 0; i < 8; i++) write_reg(3'(i), reg_val[i]);
      @(negedge clk) cfg_valid <= 1'b0;

      in_gaps_on  = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);

      // Mostly ticks in high and low bursts so trips and retries happen.
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 14) == 0) hi = !hi;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) smp = 10'($urandom_range(0, 1023));
        else if (hi) smp = 10'($urandom_range((th < 1023) ? th + 1 : 1023, 1023));
        else smp = 10'($urandom_range(0, th));
        if (r < 58)      queue_item(FUNC_TICK, 1'($urandom_range(0, 1)), smp);
        else if (r < 72) queue_item(FUNC_POWER, $urandom_range(0, 3) != 0, smp);
        else if (r < 82) queue_item(FUNC_SIGNAL, 1'($urandom_range(0, 1)), smp);
        else if (r < 90) queue_item(FUNC_BRAKE, 1'($urandom_range(0, 1)), smp);
        else if (r < 95) queue_item(FUNC_INIT, 1'($urandom_range(0, 1)), smp);
        else if (r < 98) queue_item(3'($urandom_range(FUNC_RSVD5, FUNC_RSVD7)),
                                    1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)));
        else             queue_item(FUNC_TICK, 1'b0, 10'(th));
      end
      wait_drained();
    end

    // Let any late result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
